FILE: rtl/periodic_task_tick_scheduler_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the periodic task tick scheduler
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TASK_TICK_SCHEDULER_DEFINES_SVH
`define PERIODIC_TASK_TICK_SCHEDULER_DEFINES_SVH

// Same-cycle implication
`define PTTS_ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("ptts check failed");

// Next-cycle implication
`define PTTS_ASSERT_NXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("ptts check failed");

`endif

FILE: rtl/ptts_pkg.sv
// ----------------------------------------------------------------------------
// ptts_pkg
// Shared sizes, codes and types of the periodic task tick scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package ptts_pkg;

  localparam int NUM_TASKS = 16;
  localparam int IDX_W     = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int CNT_W     = $clog2(NUM_TASKS + 1);
  localparam int VAL_W     = 16;
  localparam int TIME_W    = 32;
  localparam int RUN_W     = 4;
  localparam int IN_W      = 40;
  localparam int OUT_W     = 40;
  localparam int CFG_W     = 5;

  // Input commands
  localparam logic [1:0] CMD_LOAD    = 2'd0;
  localparam logic [1:0] CMD_TICK    = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;

  // Configuration register indexes
  localparam logic CFG_MODE  = 1'b0;
  localparam logic CFG_COUNT = 1'b1;

  // Per-task dynamic state
  typedef struct packed {
    logic [VAL_W-1:0] rem;
    logic [VAL_W-1:0] cd;
  } dyn_t;

  // One entry as seen by the selection stage
  typedef struct packed {
    logic [VAL_W-1:0] exec_time;
    logic [VAL_W-1:0] period;
    dyn_t             dyn;
  } ent_t;

  // Control from the sequencer to the selection stage
  typedef struct packed {
    logic             start;
    logic             proc;
    logic             mode;
  } sel_ctl_t;

  // Current winner of a scan
  typedef struct packed {
    logic             vld;
    logic [IDX_W-1:0] idx;
    dyn_t             dyn;
  } best_t;

endpackage

`default_nettype wire

FILE: rtl/ptts_sel.sv
// ----------------------------------------------------------------------------
// ptts_sel
// Release and selection stage: applies the release rule to one entry per
// cycle, gives its write-back value and keeps the best candidate so far.
// ----------------------------------------------------------------------------
`default_nettype none

module ptts_sel import ptts_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  sel_ctl_t         ctl,
  input  logic [IDX_W-1:0] ent_idx,
  input  ent_t             ent,
  output dyn_t             wr_dyn,
  output best_t            best
);

  logic             rel;
  logic [VAL_W-1:0] rem1;
  logic [VAL_W-1:0] cd1;
  logic [VAL_W-1:0] key;
  logic [VAL_W-1:0] cdn;
  logic             take;

  logic             best_vld_r;
  logic [IDX_W-1:0] best_idx_r;
  logic [VAL_W-1:0] best_key_r;
  dyn_t             best_dyn_r;

  // Release on zero countdown, then pick key and decremented countdown
  always_comb begin
    rel    = (ent.dyn.cd == '0);
    rem1   = rel ? ent.exec_time : ent.dyn.rem;
    cd1    = rel ? ent.period    : ent.dyn.cd;
    key    = ctl.mode ? cd1 : ent.period;
    cdn    = (cd1 != '0) ? (cd1 - VAL_W'(1)) : '0;
    take   = ctl.proc && (rem1 != '0) && (!best_vld_r || (key < best_key_r));
    wr_dyn = '{rem: rem1, cd: cdn};
  end

  // Hold the winner flag; strict compare keeps the lowest index on ties
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_vld_r <= 1'b0;
    end else if (ctl.start) begin
      best_vld_r <= 1'b0;
    end else if (take) begin
      best_vld_r <= 1'b1;
    end
  end

  // Capture winner payload with its work already charged for this tick
  always_ff @(posedge clk) begin
    if (take) begin
      best_idx_r <= ent_idx;
      best_key_r <= key;
      best_dyn_r <= '{rem: rem1 - VAL_W'(1), cd: cdn};
    end
  end

  assign best = '{vld: best_vld_r, idx: best_idx_r, dyn: best_dyn_r};

endmodule

`default_nettype wire

FILE: rtl/periodic_task_tick_scheduler.sv
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler
// Rate-monotonic / earliest-deadline-first tick scheduler over a task table.
// ----------------------------------------------------------------------------
// A load or restart transfer gives no result. A tick runs from its transfer
// to its result in these steps: the scan reads the first active_task_count
// entries (count capped at NUM_TASKS) one per cycle through the single read
// port of the task memories, each entry is released, compared and written
// back as it streams past, the read pipeline drains the last entry, and a
// final step charges one tick of work to the winner and loads the output
// register. The next item is taken while a result still waits in the output
// register; a tick result waits for that register to drain. Restart clears
// the dynamic state through per-entry valid bits; the task table itself
// keeps its contents.
`default_nettype none

module periodic_task_tick_scheduler import ptts_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // Input stream: command[1:0], task_index[5:2], exec_time[21:6],
  // task_period[37:22], zero pad [39:38]
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_W-1:0]   in_tdata,
  // Result stream: busy_res[0], running_task[4:1], tick_time[36:5],
  // zero pad [39:37]
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_W-1:0]  out_tdata,
  // Configuration write port
  input  logic              cfg_wen,
  input  logic              cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata
);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FIN} state_t;

  state_t             state_r;
  logic [CNT_W-1:0]   idx_r;
  logic               proc_r;
  logic [IDX_W-1:0]   proc_idx_r;
  logic [TIME_W-1:0]  time_r;
  logic               mode_r;
  logic [CFG_W-1:0]   count_r;
  logic               out_valid_r;
  logic               out_busy_r;
  logic [RUN_W-1:0]   out_task_r;
  logic [TIME_W-1:0]  out_time_r;
  logic [NUM_TASKS-1:0] dyn_vld_r;

  logic [2*VAL_W-1:0] tbl_mem [NUM_TASKS];
  dyn_t               dyn_mem [NUM_TASKS];
  logic [2*VAL_W-1:0] tbl_rd_r;
  dyn_t               dyn_rd_r;
  logic               vld_rd_r;

  logic [1:0]         in_cmd;
  logic [3:0]         in_task_index;
  logic [VAL_W-1:0]   in_exec_time;
  logic [VAL_W-1:0]   in_task_period;
  logic               in_fire;
  logic               slot_free;
  logic [CNT_W-1:0]   cnt_eff;
  logic               issue;
  logic [IDX_W-1:0]   rd_addr;
  logic               load_ok;
  sel_ctl_t           sel_ctl;
  ent_t               ent;
  dyn_t               wr_dyn;
  best_t              best;

  // Unpack the input item
  assign in_cmd         = in_tdata[1:0];
  assign in_task_index  = in_tdata[5:2];
  assign in_exec_time   = in_tdata[21:6];
  assign in_task_period = in_tdata[37:22];

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;
  assign load_ok   = (32'(in_task_index) < NUM_TASKS);

  // Saturate the active count and drive the scan read address
  assign cnt_eff = (32'(count_r) > NUM_TASKS) ? CNT_W'(NUM_TASKS) : CNT_W'(count_r);
  assign issue   = (state_r == ST_SCAN) && (idx_r < cnt_eff);
  assign rd_addr = idx_r[IDX_W-1:0];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 1'b0;
      count_r <= CFG_W'(1);
    end else if (cfg_wen) begin
      case (cfg_index)
        CFG_MODE:  mode_r  <= cfg_wdata[0];
        CFG_COUNT: count_r <= cfg_wdata;
        default:   ;
      endcase
    end
  end

  // Sequencer, time counter and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      proc_r      <= 1'b0;
      time_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      proc_r <= issue;
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_fire && (in_cmd == CMD_TICK)) begin
            state_r <= ST_SCAN;
            idx_r   <= '0;
          end else if (in_fire && (in_cmd == CMD_RESTART)) begin
            time_r <= '0;
          end
        end
        ST_SCAN: begin
          if (issue) begin
            idx_r <= idx_r + CNT_W'(1);
          end else if (!proc_r) begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            out_busy_r  <= best.vld;
            out_task_r  <= best.vld ? RUN_W'(best.idx) : '0;
            out_time_r  <= time_r;
            time_r      <= time_r + TIME_W'(1);
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Track the entry under processing, registered from its read address
  always_ff @(posedge clk) begin
    proc_idx_r <= rd_addr;
  end

  // Valid bits of the dynamic state: restart clears, write-back sets
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dyn_vld_r <= '0;
    end else if (in_fire && (in_cmd == CMD_RESTART)) begin
      dyn_vld_r <= '0;
    end else if (proc_r) begin
      dyn_vld_r[proc_idx_r] <= 1'b1;
    end
  end

  // Task table memory: load writes, scan reads
  always_ff @(posedge clk) begin
    if (in_fire && (in_cmd == CMD_LOAD) && load_ok) begin
      tbl_mem[IDX_W'(in_task_index)] <= {in_exec_time, in_task_period};
    end
    if (issue) begin
      tbl_rd_r <= tbl_mem[rd_addr];
    end
  end

  // Dynamic state memory: scan write-back, then winner update at the end
  always_ff @(posedge clk) begin
    if (proc_r) begin
      dyn_mem[proc_idx_r] <= wr_dyn;
    end else if ((state_r == ST_FIN) && slot_free && best.vld) begin
      dyn_mem[best.idx] <= best.dyn;
    end
    if (issue) begin
      dyn_rd_r <= dyn_mem[rd_addr];
      vld_rd_r <= dyn_vld_r[rd_addr];
    end
  end

  // Entry view with cleared state where the valid bit is low
  always_comb begin
    ent.exec_time = tbl_rd_r[2*VAL_W-1:VAL_W];
    ent.period    = tbl_rd_r[VAL_W-1:0];
    ent.dyn       = vld_rd_r ? dyn_rd_r : '0;
    sel_ctl       = '{start: in_fire && (in_cmd == CMD_TICK), proc: proc_r, mode: mode_r};
  end

  ptts_sel u_sel (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (sel_ctl),
    .ent_idx (proc_idx_r),
    .ent     (ent),
    .wr_dyn  (wr_dyn),
    .best    (best)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_time_r, out_task_r, out_busy_r};

endmodule

`default_nettype wire

FILE: rtl/ptts_chk.sv
// ----------------------------------------------------------------------------
// ptts_chk
// Port-level checks of the periodic task tick scheduler, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "periodic_task_tick_scheduler_defines.svh"

module ptts_chk import ptts_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,
  input  logic             out_tvalid,
  input  logic             out_tready,
  input  logic [OUT_W-1:0] out_tdata
);

  logic in_xfer;
  logic out_stall;

  assign in_xfer   = in_tvalid && in_tready;
  assign out_stall = out_tvalid && !out_tready;

  // A stalled result holds
  `PTTS_ASSERT_NXT(a_out_hold, out_stall, out_tvalid && $stable(out_tdata))

  // An idle tick reports task zero
  `PTTS_ASSERT_IMP(a_idle_task, out_tvalid && !out_tdata[0], out_tdata[4:1] == 4'd0)

  // A tick keeps the input closed while the scan runs
  `PTTS_ASSERT_NXT(a_tick_busy, in_xfer && (in_tdata[1:0] == CMD_TICK), !in_tready)

  // A load, restart or ignored command never raises a result
  `PTTS_ASSERT_NXT(a_no_result, in_xfer && (in_tdata[1:0] != CMD_TICK), !$rose(out_tvalid))

endmodule

bind periodic_task_tick_scheduler ptts_chk u_ptts_chk (.*);

`default_nettype wire

FILE: tb/tb_periodic_task_tick_scheduler.sv
// ----------------------------------------------------------------------------
// tb_periodic_task_tick_scheduler
// Self-checking bench for the rate-monotonic / EDF tick scheduler. It drives
// load, tick, restart and unknown commands and tracks the task table in a
// scoreboard that predicts every tick result. Both stream sides idle and
// stall at random, and a long output stall backs the block up.
// ----------------------------------------------------------------------------
module tb_periodic_task_tick_scheduler;
  timeunit 1ns;
  timeprecision 1ps;
  import ptts_pkg::*;

  localparam logic [1:0] CMD_UNKNOWN = 2'd3;
  localparam int SETTLE_CYC = NUM_TASKS + 8;
  localparam int LONG_HOLD  = 300;
  localparam int STALL_LIMIT = 20000;

  // One tick result
  typedef struct packed {
    logic              busy;
    logic [RUN_W-1:0]  run_idx;
    logic [TIME_W-1:0] stamp;
  } tick_out_t;

  // Tracks the task table and schedule, predicts each tick result
  class tick_schedule_board;
    logic [VAL_W-1:0]  exec_tab [NUM_TASKS];
    logic [VAL_W-1:0]  per_tab  [NUM_TASKS];
    logic [VAL_W-1:0]  work_left[NUM_TASKS];
    logic [VAL_W-1:0]  countdown[NUM_TASKS];
    logic [TIME_W-1:0] now;
    logic              policy_edf;
    logic [CFG_W-1:0]  active_cnt;
    tick_out_t         pending[$];
    int                mismatches;
    int                ticks_checked;
    int                busy_checked;

    function new();
      for (int i = 0; i < NUM_TASKS; i++) begin
        exec_tab[i]  = '0;
        per_tab[i]   = '0;
        work_left[i] = '0;
        countdown[i] = '0;
      end
      now           = '0;
      policy_edf    = 1'b0;
      active_cnt    = 1;
      mismatches    = 0;
      ticks_checked = 0;
      busy_checked  = 0;
    endfunction

    function void set_reg(logic idx, logic [CFG_W-1:0] val);
      if (idx == CFG_MODE) policy_edf = val[0];
      else active_cnt = val;
    endfunction

    // Apply one accepted input transfer
    function void note_item(logic [IN_W-1:0] d);
      logic [1:0]       cmd;
      logic [3:0]       idx;
      int               n;
      int               pick;
      int               i;
      logic [VAL_W-1:0] best;
      logic [VAL_W-1:0] key;
      tick_out_t        r;
      cmd = d[1:0];
      idx = d[5:2];
      case (cmd)
        CMD_LOAD: begin
          exec_tab[idx] = d[21:6];
          per_tab[idx]  = d[37:22];
        end
        CMD_RESTART: begin
          for (i = 0; i < NUM_TASKS; i++) begin
            work_left[i] = '0;
            countdown[i] = '0;
          end
          now = '0;
        end
        CMD_TICK: begin
          n = (active_cnt > NUM_TASKS) ? NUM_TASKS : int'(active_cnt);
          // release due tasks
          for (i = 0; i < n; i++) begin
            if (countdown[i] == 0) begin
              work_left[i] = exec_tab[i];
              countdown[i] = per_tab[i];
            end
          end
          // pick smallest key, lowest index wins ties
          pick = -1;
          best = '0;
          for (i = 0; i < n; i++) begin
            if (work_left[i] != 0) begin
              key = policy_edf ? countdown[i] : per_tab[i];
              if (pick < 0 || key < best) begin
                pick = i;
                best = key;
              end
            end
          end
          r.busy    = (pick >= 0);
          r.run_idx = (pick >= 0) ? pick[RUN_W-1:0] : '0;
          r.stamp   = now;
          pending.push_back(r);
          if (pick >= 0) work_left[pick] = work_left[pick] - 1'b1;
          // advance countdowns and time
          for (i = 0; i < n; i++) begin
            if (countdown[i] != 0) countdown[i] = countdown[i] - 1'b1;
          end
          now = now + 1'b1;
        end
        default: ;
      endcase
    endfunction

    // Compare one result transfer with the oldest prediction
    function void check_tick(logic [OUT_W-1:0] d);
      tick_out_t got;
      tick_out_t want;
      got.busy    = d[0];
      got.run_idx = d[4:1];
      got.stamp   = d[36:5];
      ticks_checked++;
      if (got.busy) busy_checked++;
      if (pending.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected tick result expected none, actual busy=%0b task=%0d time=%0d",
                 $time, got.busy, got.run_idx, got.stamp);
        return;
      end
      want = pending.pop_front();
      if (got.busy !== want.busy || got.run_idx !== want.run_idx ||
          got.stamp !== want.stamp) begin
        mismatches++;
        $display("%0t: tick mismatch expected busy=%0b task=%0d time=%0d, actual busy=%0b task=%0d time=%0d",
                 $time, want.busy, want.run_idx, want.stamp,
                 got.busy, got.run_idx, got.stamp);
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic             cfg_wen = 1'b0;
  logic             cfg_index = CFG_MODE;
  logic [CFG_W-1:0] cfg_wdata = '0;

  tick_schedule_board sched_sb = new();
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_seq = 0;
  int items_in = 0;
  int quiet_cycles = 0;

  periodic_task_tick_scheduler u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: random stalls, plus a long hold-off when asked
  int hold_seen = 0;
  int hold_left = 0;
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Monitor both streams at the clock edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sched_sb.check_tick(out_tdata);
      if (in_tvalid && in_tready) begin
        sched_sb.note_item(in_tdata);
        items_in++;
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [IN_W-1:0] pack_item(logic [1:0] cmd, logic [3:0] idx,
                                                logic [15:0] ex, logic [15:0] per);
    return {2'b00, per, ex, idx, cmd};
  endfunction

  function automatic logic [15:0] rand_exec();
    return ($urandom_range(99) < 90) ? 16'($urandom_range(0, 4))
                                     : 16'($urandom_range(0, 65535));
  endfunction

  function automatic logic [15:0] rand_period();
    int roll;
    roll = $urandom_range(99);
    if (roll < 85) return 16'($urandom_range(1, 24));
    if (roll < 95) return 16'($urandom_range(0, 65535));
    return 16'd0;
  endfunction

  // Offer one item and hold it until the transfer
  task automatic send_item(logic [1:0] cmd, logic [3:0] idx, logic [15:0] ex,
                           logic [15:0] per);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pack_item(cmd, idx, ex, per);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_tick();
    send_item(CMD_TICK, 4'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // Drop valid, let the monitor note the last transfer, wait for all
  // results, then let the block go quiet
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sched_sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sched_sb.set_reg(idx, val);
    cfg_wen <= 1'b0;
    @(posedge clk);
  endtask

  // Random mix of commands, ticks dominating
  task automatic run_segment(int n_items);
    int roll;
    for (int k = 0; k < n_items; k++) begin
      roll = $urandom_range(99);
      if (roll < 68) send_tick();
      else if (roll < 93)
        send_item(CMD_LOAD, 4'($urandom), rand_exec(), rand_period());
      else if (roll < 97)
        send_item(CMD_RESTART, 4'($urandom), 16'($urandom), 16'($urandom));
      else
        send_item(CMD_UNKNOWN, 4'($urandom), 16'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    int pick;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill the whole table before any tick reads it
    write_reg(CFG_MODE, 5'd0);
    write_reg(CFG_COUNT, 5'd16);
    for (int i = 0; i < NUM_TASKS; i++)
      send_item(CMD_LOAD, 4'(i), 16'($urandom_range(1, 3)), 16'($urandom_range(4, 12)));

    // Directed: period zero, field extremes, zero work, unknown command, restart
    send_item(CMD_LOAD, 4'd0, 16'd2, 16'd0);
    send_item(CMD_LOAD, 4'd15, 16'hFFFF, 16'hFFFF);
    send_item(CMD_LOAD, 4'd3, 16'd0, 16'd1);
    send_item(CMD_LOAD, 4'd7, 16'd1, 16'd1);
    repeat (4) send_tick();
    send_item(CMD_UNKNOWN, 4'hF, 16'hFFFF, 16'hFFFF);
    send_tick();
    send_item(CMD_RESTART, 4'h0, 16'h0, 16'h0);
    repeat (2) send_tick();
    settle();
    write_reg(CFG_MODE, 5'd1);
    repeat (3) send_tick();
    // No active task: every tick idle
    settle();
    write_reg(CFG_COUNT, 5'd0);
    repeat (2) send_tick();
    // Count above table size saturates
    settle();
    write_reg(CFG_COUNT, 5'd31);
    repeat (2) send_tick();
    settle();
    write_reg(CFG_COUNT, 5'd1);
    send_tick();

    // Random phases with different handshake mixes
    for (int ph = 0; ph < 3; ph++) begin
      settle();
      tx_idle_pct = (ph == 0) ? 34 : (ph == 1) ? 86 : 0;
      rx_idle_pct = (ph == 0) ? 86 : (ph == 1) ? 34 : 0;
      for (int seg = 0; seg < 4; seg++) begin
        settle();
        write_reg(CFG_MODE, 5'($urandom_range(0, 1)));
        pick = $urandom_range(9);
        case (pick)
          0: write_reg(CFG_COUNT, 5'd1);
          1: write_reg(CFG_COUNT, 5'd16);
          2: write_reg(CFG_COUNT, 5'd0);
          3: write_reg(CFG_COUNT, 5'($urandom_range(17, 31)));
          default: write_reg(CFG_COUNT, 5'($urandom_range(2, 15)));
        endcase
        // Stall the output long enough to back the block up
        if (ph == 2 && seg == 0) hold_seq <= hold_seq + 1;
        run_segment(70);
      end
    end

    settle();
    if (sched_sb.pending.size() != 0) begin
      sched_sb.mismatches++;
      $display("%0t: %0d tick results never arrived", $time, sched_sb.pending.size());
    end
    $display("Run covered %0d input transfers and %0d tick results (%0d busy),",
             items_in, sched_sb.ticks_checked, sched_sb.busy_checked);
    $display("both policies, active counts 0 to 31, three stall mixes and a long hold-off.");
    if (sched_sb.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/ptts_pkg.sv
rtl/ptts_sel.sv
rtl/periodic_task_tick_scheduler.sv
rtl/ptts_chk.sv
tb/tb_periodic_task_tick_scheduler.sv
